### hdl/ctkm_pkg.sv
// shared types and constants for the cosine top-k match block
`default_nettype none

package ctkm_pkg;

    localparam int NUM_SLOTS_DEF  = 256;
    localparam int VECTOR_DIM_DEF = 512;
    localparam int TOP_K_MAX_DEF  = 16;

    localparam logic [4:0]        TOP_K_RST = 5'd5;
    localparam logic signed [15:0] THR_RST  = 16'sd0;

    localparam int NORM_SHIFT  = 20;
    localparam int QUO_W       = 19;
    localparam int DIV_PRESHIFT = 36 - QUO_W;
    localparam int DIV_CNT_W   = 5;

    localparam logic signed [15:0] SIM_MAX = 16'sh7fff;
    localparam logic signed [15:0] SIM_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        MODE_STORE  = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_REMOVE = 2'd0,
        KIND_MATCH  = 2'd1,
        KIND_NONE   = 2'd2
    } kind_t;

    typedef enum logic {
        REG_TOP_K     = 1'b0,
        REG_THRESHOLD = 1'b1
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN,
        ST_CHK,
        ST_MAC,
        ST_DRAIN,
        ST_NORM,
        ST_SQRT,
        ST_MUL,
        ST_DIVI,
        ST_DIV,
        ST_RND,
        ST_INS,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

### hdl/ctkm_isqrt.sv
// iterative integer square root, two radicand bits per cycle
`default_nettype none

module ctkm_isqrt #(
    parameter int XW = 62
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [XW-1:0]     x,
    output logic                   done,
    output logic [XW/2-1:0]        root
);

    localparam int RW    = XW / 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [XW-1:0]    x_reg;
    logic [RW+1:0]    rem_reg;
    logic [RW-1:0]    root_reg;

    logic [RW+1:0]    rem_sh;
    logic [RW+1:0]    trial;
    logic             fits;

    assign rem_sh = {rem_reg[RW-1:0], x_reg[XW-1:XW-2]};
    assign trial  = {root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(RW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= x;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg <= {x_reg[XW-3:0], 2'b00};
            if (fits) begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

### hdl/cosine_topk_match_thresholded.sv
// top level: vector store, query buffer and cosine top-k search sequencer
//
// Input words (s_*) carry a mode, a slot, one Q1.15 element and a last flag.
// Store words write one element each into the slot's vector; the last one
// sets the length and marks the slot valid. A remove word answers with one
// word on m_* (kind 0, found). Query words fill the query buffer; the last one
// starts a search over every slot, and the block takes no input word until
// the final result word of that search has been loaded into the output
// register. Results are the kept matches best first (kind 1) or a single
// kind 2 word, with end_of_run on the final word.
// Store and query words do not wait for the output register; a remove reply
// appears the cycle after acceptance. A search steps through the slots in
// order; a valid slot whose length matches the query is scored by the
// element-serial multiply-accumulate over the vector memory, the bit-serial
// square roots and the 19-step divider, and the result words follow.
// A stalled m_ready holds the output register; search results wait for it.
// Reset clears the valid bits, counters and control registers (top_k 5,
// threshold 0), not memories or data registers. cfg_* writes are always taken.
`default_nettype none

module cosine_topk_match_thresholded #(
    parameter int NUM_SLOTS  = ctkm_pkg::NUM_SLOTS_DEF,
    parameter int VECTOR_DIM = ctkm_pkg::VECTOR_DIM_DEF,
    parameter int TOP_K_MAX  = ctkm_pkg::TOP_K_MAX_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_mode,
    input  wire logic [7:0]         s_slot,
    input  wire logic signed [15:0] s_value,
    input  wire logic               s_last,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_kind,
    output logic                    m_found,
    output logic [7:0]              m_match_slot,
    output logic signed [15:0]      m_similarity,
    output logic                    m_end_of_run,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [15:0]        cfg_data
);

    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int DIM_W   = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
    localparam int LEN_W   = $clog2(VECTOR_DIM + 1);
    localparam int NORM_W  = 31 + DIM_W;
    localparam int DOT_W   = NORM_W + 1;
    localparam int XRAW    = NORM_W + ctkm_pkg::NORM_SHIFT;
    localparam int XW      = XRAW + (XRAW % 2);
    localparam int RW      = XW / 2;
    localparam int DEN_W   = 2 * RW;
    localparam int DR_W    = DEN_W + 1;
    localparam int KW      = $clog2(TOP_K_MAX + 1);
    localparam int KIW     = (TOP_K_MAX > 1) ? $clog2(TOP_K_MAX) : 1;
    localparam int QW      = ctkm_pkg::QUO_W;
    localparam int CW      = ctkm_pkg::DIV_CNT_W;
    localparam int VEC_DEPTH = NUM_SLOTS * (2 ** DIM_W);

    ctkm_pkg::state_t state_reg, state_next;
    ctkm_pkg::mode_t  in_mode;

    logic [4:0]               top_k_reg;
    logic signed [15:0]       thr_reg;
    logic [NUM_SLOTS-1:0]     valid_reg;
    logic [LEN_W-1:0]         wc_reg;
    logic [LEN_W-1:0]         ql_reg;
    logic [LEN_W-1:0]         qlen_reg;
    logic [SLOT_W-1:0]        s_idx_reg;
    logic [DIM_W-1:0]         i_reg;
    logic                     rd_vld_reg;
    logic [CW-1:0]            cnt_reg;
    logic [KW-1:0]            k_reg;
    logic [KW-1:0]            n_reg;
    logic [KIW-1:0]           out_idx_reg;

    logic [LEN_W-1:0]         len_rd_reg;
    logic signed [15:0]       vec_rd_reg;
    logic signed [15:0]       q_rd_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    logic [NORM_W-1:0]        na_reg;
    logic [NORM_W-1:0]        nb_reg;
    logic [NORM_W-1:0]        mag_reg;
    logic                     neg_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [DR_W-1:0]          div_r_reg;
    logic [QW-1:0]            q_reg;
    logic                     ovf_reg;
    logic signed [15:0]       sim_reg;

    logic signed [15:0]       best_sim_reg  [TOP_K_MAX];
    logic [SLOT_W-1:0]        best_slot_reg [TOP_K_MAX];

    logic                     m_valid_reg;
    logic [1:0]               m_kind_reg;
    logic                     m_found_reg;
    logic [7:0]               m_slot_reg;
    logic signed [15:0]       m_sim_reg;
    logic                     m_eor_reg;

    logic signed [15:0]       vec_mem [VEC_DEPTH];
    logic signed [15:0]       qbuf_mem [VECTOR_DIM];
    logic [LEN_W-1:0]         len_mem [NUM_SLOTS];

    logic                     acc;
    logic                     in_range;
    logic [SLOT_W-1:0]        slot_idx;
    logic                     out_free;
    logic [LEN_W-1:0]         wc_inc;
    logic [LEN_W-1:0]         ql_inc;
    logic                     wc_room;
    logic                     ql_room;
    logic                     start_search;
    logic                     last_slot;
    logic                     i_last;
    logic                     norm_zero;
    logic                     sq_start;
    logic                     sq_done_a;
    logic                     sq_done_b;
    logic                     sq_done;
    logic [RW-1:0]            ra;
    logic [RW-1:0]            rb;
    logic [DR_W-1:0]          r_sh;
    logic                     r_fit;
    logic [QW:0]              rnd;
    logic [TOP_K_MAX-1:0]     inl;
    logic [TOP_K_MAX-1:0]     ge;
    logic                     drop;
    logic                     take;
    logic                     out_last;
    logic                     load_srch;
    logic                     load_rm;
    logic signed [31:0]       p_ab;
    logic signed [31:0]       p_aa;
    logic signed [31:0]       p_bb;
    logic [KW-1:0]            k_eff;

    assign in_mode  = ctkm_pkg::mode_t'(s_mode);
    assign acc      = s_valid && s_ready;
    assign in_range = 32'(s_slot) < NUM_SLOTS;
    assign slot_idx = SLOT_W'(s_slot);
    assign out_free = !m_valid_reg || m_ready;
    assign wc_inc   = wc_reg + LEN_W'(1);
    assign ql_inc   = ql_reg + LEN_W'(1);
    assign wc_room  = 32'(wc_reg) < VECTOR_DIM;
    assign ql_room  = 32'(ql_reg) < VECTOR_DIM;
    assign start_search = acc && in_mode == ctkm_pkg::MODE_QUERY && s_last;
    assign last_slot = s_idx_reg == SLOT_W'(NUM_SLOTS - 1);
    assign i_last    = (LEN_W + 1)'(i_reg) + (LEN_W + 1)'(1) == (LEN_W + 1)'(qlen_reg);
    assign norm_zero = na_reg == '0 || nb_reg == '0;
    assign sq_done   = sq_done_a && sq_done_b;
    assign out_last  = n_reg == '0 || KW'(out_idx_reg) + KW'(1) == n_reg;
    assign k_eff     = (32'(top_k_reg) > TOP_K_MAX) ? KW'(TOP_K_MAX) : KW'(top_k_reg);
    assign cfg_ready = 1'b1;

    assign r_sh  = {div_r_reg[DR_W-2:0], 1'b0};
    assign r_fit = r_sh >= {1'b0, den_reg};
    assign rnd   = ((QW + 1)'(q_reg) + (QW + 1)'(1)) >> 1;

    assign p_ab = q_rd_reg * vec_rd_reg;
    assign p_aa = q_rd_reg * q_rd_reg;
    assign p_bb = vec_rd_reg * vec_rd_reg;

    always_comb begin
        for (int j = 0; j < TOP_K_MAX; j++) begin
            inl[j] = KW'(j) < n_reg;
            ge[j]  = inl[j] && (best_sim_reg[j] >= sim_reg);
        end
    end

    assign drop = (n_reg == k_reg) && (&(ge | ~inl));
    assign take = (sim_reg >= thr_reg) && (k_reg != '0) && !drop;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ctkm_pkg::ST_IDLE:  if (start_search) state_next = ctkm_pkg::ST_LEN;
            ctkm_pkg::ST_LEN: begin
                if (valid_reg[s_idx_reg]) state_next = ctkm_pkg::ST_CHK;
                else if (last_slot)      state_next = ctkm_pkg::ST_OUT;
            end
            ctkm_pkg::ST_CHK: begin
                if (len_rd_reg != qlen_reg || len_rd_reg == '0)
                    state_next = ctkm_pkg::ST_INS;
                else
                    state_next = ctkm_pkg::ST_MAC;
            end
            ctkm_pkg::ST_MAC:   if (i_last) state_next = ctkm_pkg::ST_DRAIN;
            ctkm_pkg::ST_DRAIN: state_next = ctkm_pkg::ST_NORM;
            ctkm_pkg::ST_NORM: begin
                if (norm_zero) state_next = ctkm_pkg::ST_INS;
                else           state_next = ctkm_pkg::ST_SQRT;
            end
            ctkm_pkg::ST_SQRT:  if (sq_done) state_next = ctkm_pkg::ST_MUL;
            ctkm_pkg::ST_MUL:   state_next = ctkm_pkg::ST_DIVI;
            ctkm_pkg::ST_DIVI:  state_next = ctkm_pkg::ST_DIV;
            ctkm_pkg::ST_DIV:   if (cnt_reg == CW'(QW - 1)) state_next = ctkm_pkg::ST_RND;
            ctkm_pkg::ST_RND:   state_next = ctkm_pkg::ST_INS;
            ctkm_pkg::ST_INS: begin
                if (last_slot) state_next = ctkm_pkg::ST_OUT;
                else           state_next = ctkm_pkg::ST_LEN;
            end
            ctkm_pkg::ST_OUT:   if (out_free && out_last) state_next = ctkm_pkg::ST_IDLE;
            default:            state_next = ctkm_pkg::ST_IDLE;
        endcase
    end

    // fsm outputs
    always_comb begin
        s_ready   = 1'b0;
        sq_start  = 1'b0;
        load_srch = 1'b0;
        unique case (state_reg)
            ctkm_pkg::ST_IDLE: s_ready = in_mode != ctkm_pkg::MODE_REMOVE || out_free;
            ctkm_pkg::ST_NORM: sq_start = !norm_zero;
            ctkm_pkg::ST_OUT:  load_srch = out_free;
            default: ;
        endcase
    end

    assign load_rm = acc && in_mode == ctkm_pkg::MODE_REMOVE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ctkm_pkg::ST_IDLE;
            top_k_reg   <= ctkm_pkg::TOP_K_RST;
            thr_reg     <= ctkm_pkg::THR_RST;
            valid_reg   <= '0;
            wc_reg      <= '0;
            ql_reg      <= '0;
            s_idx_reg   <= '0;
            i_reg       <= '0;
            rd_vld_reg  <= 1'b0;
            cnt_reg     <= '0;
            k_reg       <= '0;
            n_reg       <= '0;
            out_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            rd_vld_reg <= state_reg == ctkm_pkg::ST_MAC;

            if (cfg_valid && cfg_ready) begin
                unique case (ctkm_pkg::cfg_reg_t'(cfg_index))
                    ctkm_pkg::REG_TOP_K:     top_k_reg <= cfg_data[4:0];
                    ctkm_pkg::REG_THRESHOLD: thr_reg   <= cfg_data;
                endcase
            end

            if (acc && in_mode == ctkm_pkg::MODE_STORE && in_range) begin
                if (wc_reg == '0) valid_reg[slot_idx] <= 1'b0;
                if (s_last) begin
                    valid_reg[slot_idx] <= 1'b1;
                    wc_reg <= '0;
                end else if (wc_room) begin
                    wc_reg <= wc_inc;
                end
            end
            if (load_rm && in_range) valid_reg[slot_idx] <= 1'b0;

            if (acc && in_mode == ctkm_pkg::MODE_QUERY) begin
                if (s_last)       ql_reg <= '0;
                else if (ql_room) ql_reg <= ql_inc;
            end

            if (start_search) begin
                s_idx_reg   <= '0;
                k_reg       <= k_eff;
                n_reg       <= '0;
                out_idx_reg <= '0;
            end

            if ((state_reg == ctkm_pkg::ST_LEN && !valid_reg[s_idx_reg] && !last_slot) ||
                (state_reg == ctkm_pkg::ST_INS && !last_slot))
                s_idx_reg <= s_idx_reg + SLOT_W'(1);

            if (state_reg == ctkm_pkg::ST_CHK) i_reg <= '0;
            else if (state_reg == ctkm_pkg::ST_MAC) i_reg <= i_reg + DIM_W'(1);

            if (state_reg == ctkm_pkg::ST_DIVI) cnt_reg <= '0;
            else if (state_reg == ctkm_pkg::ST_DIV) cnt_reg <= cnt_reg + CW'(1);

            if (state_reg == ctkm_pkg::ST_INS && take && n_reg < k_reg)
                n_reg <= n_reg + KW'(1);

            if (load_srch && !out_last) out_idx_reg <= out_idx_reg + KIW'(1);

            if (load_rm || load_srch) m_valid_reg <= 1'b1;
            else if (m_ready)         m_valid_reg <= 1'b0;
        end
    end

    // memories
    always_ff @(posedge aclk) begin
        if (acc && in_mode == ctkm_pkg::MODE_STORE && in_range && wc_room)
            vec_mem[{slot_idx, wc_reg[DIM_W-1:0]}] <= s_value;
        vec_rd_reg <= vec_mem[{s_idx_reg, i_reg}];
    end

    always_ff @(posedge aclk) begin
        if (acc && in_mode == ctkm_pkg::MODE_QUERY && ql_room)
            qbuf_mem[ql_reg[DIM_W-1:0]] <= s_value;
        q_rd_reg <= qbuf_mem[i_reg];
    end

    always_ff @(posedge aclk) begin
        if (acc && in_mode == ctkm_pkg::MODE_STORE && in_range && s_last)
            len_mem[slot_idx] <= wc_room ? wc_inc : wc_reg;
        len_rd_reg <= len_mem[s_idx_reg];
    end

    // scoring datapath
    always_ff @(posedge aclk) begin
        if (start_search) qlen_reg <= ql_room ? ql_inc : ql_reg;

        if (state_reg == ctkm_pkg::ST_CHK) begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
            sim_reg <= '0;
        end else if (rd_vld_reg) begin
            dot_reg <= dot_reg + DOT_W'(p_ab);
            na_reg  <= na_reg + NORM_W'($unsigned(p_aa));
            nb_reg  <= nb_reg + NORM_W'($unsigned(p_bb));
        end

        if (state_reg == ctkm_pkg::ST_MUL) begin
            den_reg <= DEN_W'(ra) * DEN_W'(rb);
            neg_reg <= dot_reg < 0;
            mag_reg <= (dot_reg < 0) ? NORM_W'(-dot_reg) : NORM_W'(dot_reg);
        end

        if (state_reg == ctkm_pkg::ST_DIVI) begin
            div_r_reg <= DR_W'(mag_reg) << ctkm_pkg::DIV_PRESHIFT;
            ovf_reg   <= (DR_W'(mag_reg) << ctkm_pkg::DIV_PRESHIFT) >= DR_W'(den_reg);
            q_reg     <= '0;
        end else if (state_reg == ctkm_pkg::ST_DIV) begin
            if (r_fit) begin
                div_r_reg <= r_sh - DR_W'(den_reg);
                q_reg     <= {q_reg[QW-2:0], 1'b1};
            end else begin
                div_r_reg <= r_sh;
                q_reg     <= {q_reg[QW-2:0], 1'b0};
            end
        end

        if (state_reg == ctkm_pkg::ST_RND) begin
            if (neg_reg) begin
                if (ovf_reg || rnd > (QW + 1)'(32768)) sim_reg <= ctkm_pkg::SIM_MIN;
                else sim_reg <= 16'((QW + 1)'(0) - rnd);
            end else begin
                if (ovf_reg || rnd > (QW + 1)'(32767)) sim_reg <= ctkm_pkg::SIM_MAX;
                else sim_reg <= 16'(rnd);
            end
        end
    end

    ctkm_isqrt #(.XW(XW)) u_sqrt_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .x       (XW'(na_reg) << ctkm_pkg::NORM_SHIFT),
        .done    (sq_done_a),
        .root    (ra)
    );

    ctkm_isqrt #(.XW(XW)) u_sqrt_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .x       (XW'(nb_reg) << ctkm_pkg::NORM_SHIFT),
        .done    (sq_done_b),
        .root    (rb)
    );

    // best list, sorted insert
    for (genvar j = 0; j < TOP_K_MAX; j++) begin : g_best
        always_ff @(posedge aclk) begin
            if (state_reg == ctkm_pkg::ST_INS && take && !ge[j]) begin
                if (j == 0) begin
                    best_sim_reg[j]  <= sim_reg;
                    best_slot_reg[j] <= s_idx_reg;
                end else if (ge[(j > 0) ? j - 1 : 0]) begin
                    best_sim_reg[j]  <= sim_reg;
                    best_slot_reg[j] <= s_idx_reg;
                end else begin
                    best_sim_reg[j]  <= best_sim_reg[(j > 0) ? j - 1 : 0];
                    best_slot_reg[j] <= best_slot_reg[(j > 0) ? j - 1 : 0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (load_rm) begin
            m_kind_reg  <= ctkm_pkg::KIND_REMOVE;
            m_found_reg <= in_range && valid_reg[slot_idx];
            m_slot_reg  <= '0;
            m_sim_reg   <= '0;
            m_eor_reg   <= 1'b1;
        end else if (load_srch) begin
            m_found_reg <= 1'b0;
            m_eor_reg   <= out_last;
            if (n_reg == '0) begin
                m_kind_reg <= ctkm_pkg::KIND_NONE;
                m_slot_reg <= '0;
                m_sim_reg  <= '0;
            end else begin
                m_kind_reg <= ctkm_pkg::KIND_MATCH;
                m_slot_reg <= 8'(best_slot_reg[out_idx_reg]);
                m_sim_reg  <= best_sim_reg[out_idx_reg];
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_found      = m_found_reg;
    assign m_match_slot = m_slot_reg;
    assign m_similarity = m_sim_reg;
    assign m_end_of_run = m_eor_reg;

`ifndef SYNTHESIS
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        acc |-> state_reg == ctkm_pkg::ST_IDLE)
        else $error("input word taken during search");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= k_reg)
        else $error("best list exceeds top_k");

    a_sqrt_done: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> state_reg == ctkm_pkg::ST_SQRT)
        else $error("square root finished outside its wait state");

    a_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(wc_reg) <= VECTOR_DIM && 32'(ql_reg) <= VECTOR_DIM)
        else $error("element counter past vector dimension");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ctkm_pkg::ST_DIV && !ovf_reg |-> div_r_reg < {1'b0, den_reg})
        else $error("divider remainder not below divisor");
`endif

endmodule

`default_nettype wire
